// File: hdl/rrap_pkg.sv
// ----------------------------------------------------------------------------
// rrap_pkg: shared definitions of the Rock Ridge attribute parser
// Signature codes, result codes, and the job and result records that pass
// between the front end, the job queue and the result sequencer.
// ----------------------------------------------------------------------------
package rrap_pkg;

   // Default depth of the job queue between front end and back end.
   localparam int QueueDepthDefault = 2;

   // Entry bytes 0 through 32 are all that any handled entry ever reads.
   localparam int CapBytes = 33;

   // Width of the packed result data word (284 field bits, padded to bytes).
   localparam int RspDataBits = 288;

   // Result kinds.
   localparam logic [1:0] KindPosix = 2'd0;
   localparam logic [1:0] KindStamp = 2'd1;
   localparam logic [1:0] KindEnd   = 2'd2;

   // Timestamp targets.
   localparam logic [1:0] TargetChange = 2'd0;
   localparam logic [1:0] TargetModify = 2'd1;
   localparam logic [1:0] TargetAccess = 2'd2;

   // End-of-area status codes.
   localparam logic [1:0] EndFinished = 2'd0;
   localparam logic [1:0] EndContinue = 2'd1;
   localparam logic [1:0] EndStopped  = 2'd2;

   // Entry signatures, first byte in the upper half.
   localparam logic [15:0] SigRr = 16'h5252;
   localparam logic [15:0] SigSp = 16'h5350;
   localparam logic [15:0] SigCe = 16'h4345;
   localparam logic [15:0] SigRe = 16'h5245;
   localparam logic [15:0] SigPx = 16'h5058;
   localparam logic [15:0] SigTf = 16'h5446;

   // Entry layout and checks.
   localparam logic [7:0] LenPos      = 8'd2;
   localparam logic [7:0] VersionPos  = 8'd3;
   localparam logic [7:0] MinEntryLen = 8'd4;
   localparam logic [7:0] SpMagic0    = 8'hBE;
   localparam logic [7:0] SpMagic1    = 8'hEF;
   // RR flag bits for PX, TF, SL and CL.
   localparam logic [7:0] RrKnownMask = 8'h95;

   // Everything one accepted byte asks of the back end.
   typedef struct packed {
      logic              is_px;
      logic              is_tf;
      logic              has_end;
      logic [3:0]        tf_flags;
      logic [3:0][31:0]  px_word;
      logic [3:0][55:0]  stamp;
      logic [1:0]        end_status;
      logic [31:0]       next_extent;
      logic [31:0]       next_offset;
      logic [31:0]       next_size;
   } job_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] file_mode;
      logic [31:0] link_count;
      logic [31:0] owner_id;
      logic [31:0] group_id;
      logic [1:0]  stamp_target;
      logic [55:0] stamp_raw;
      logic [1:0]  end_status;
      logic [31:0] next_extent;
      logic [31:0] next_offset;
      logic [31:0] next_size;
      logic        result_last;
   } result_type;

   // TF flag bit to stamp target; the attributes stamp lands on change time.
   function automatic logic [1:0] stamp_target_of(input logic [1:0] flag_index);
      logic [1:0] target;
      unique case (flag_index)
         2'd0:    target = TargetChange;
         2'd1:    target = TargetModify;
         2'd2:    target = TargetAccess;
         default: target = TargetChange;
      endcase
      return target;
   endfunction

endpackage

// File: hdl/rrap_front.sv
// ----------------------------------------------------------------------------
// rrap_front: byte intake and entry classification
// Tracks the position inside the current entry, captures the entry bytes,
// handles the state-only entries and hands result work to the job queue.
// ----------------------------------------------------------------------------
module rrap_front import rrap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte,
   input  logic        req_last,
   input  logic        queue_full,
   output logic        push,
   output job_type     push_job
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic        stopped_ff, stopped_in;
   logic [31:0] cont_block_ff, cont_block_in;
   logic [31:0] cont_start_ff, cont_start_in;
   logic [31:0] cont_bytes_ff, cont_bytes_in;
   logic [7:0]  cap_ff [CapBytes];
   logic [7:0]  cap_in [CapBytes];

   logic             accept;
   logic             finish;
   logic [7:0]       eb [CapBytes];
   logic [15:0]      sig;
   logic [7:0]       flags;
   logic [3:0][31:0] words;
   logic [3:0][55:0] stamps;
   logic             px_hit;
   logic             tf_hit;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // Entry bytes as seen once the current byte is taken; bytes past the
   // current position lie beyond the entry length and read as zero.
   always_comb begin
      for (int i = 0; i < CapBytes; i++) begin
         if (8'(i) == pos_ff) begin
            eb[i] = req_byte;
         end else if (8'(i) < pos_ff) begin
            eb[i] = cap_ff[i];
         end else begin
            eb[i] = '0;
         end
      end
      for (int w = 0; w < 4; w++) begin
         words[w] = {eb[4 + 8 * w + 3], eb[4 + 8 * w + 2],
                     eb[4 + 8 * w + 1], eb[4 + 8 * w]};
      end
      for (int s = 0; s < 4; s++) begin
         for (int b = 0; b < 7; b++) begin
            stamps[s][8 * b +: 8] = eb[5 + 7 * s + b];
         end
      end
   end

   assign sig    = {eb[0], eb[1]};
   assign flags  = eb[4];
   assign finish = !stopped_ff && (pos_ff >= VersionPos) &&
                   (({1'b0, pos_ff} + 9'd1) == {1'b0, len_ff});

   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      stopped_in    = stopped_ff;
      cont_block_in = cont_block_ff;
      cont_start_in = cont_start_ff;
      cont_bytes_in = cont_bytes_ff;
      cap_in        = cap_ff;
      px_hit        = 1'b0;
      tf_hit        = 1'b0;
      push_job      = '0;
      push          = 1'b0;

      if (accept) begin
         if (!stopped_ff) begin
            for (int i = 0; i < CapBytes; i++) begin
               if (8'(i) == pos_ff) begin
                  cap_in[i] = req_byte;
               end
            end
            if (pos_ff == LenPos) begin
               len_in = req_byte;
               if (req_byte < MinEntryLen) begin
                  stopped_in = 1'b1;
               end
            end
            if (!stopped_in) begin
               if (finish) begin
                  unique case (sig)
                     SigRr: begin
                        if ((flags & RrKnownMask) == 8'd0) begin
                           stopped_in = 1'b1;
                        end
                     end
                     SigSp: begin
                        if (eb[4] != SpMagic0 || eb[5] != SpMagic1) begin
                           stopped_in = 1'b1;
                        end
                     end
                     SigCe: begin
                        cont_block_in = words[0];
                        cont_start_in = words[1];
                        cont_bytes_in = words[2];
                     end
                     SigRe: stopped_in = 1'b1;
                     SigPx: px_hit = 1'b1;
                     SigTf: tf_hit = 1'b1;
                     default: ;
                  endcase
                  pos_in = '0;
                  len_in = '0;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end

         push_job.is_px    = px_hit;
         push_job.is_tf    = tf_hit;
         push_job.has_end  = req_last;
         push_job.tf_flags = flags[3:0];
         push_job.px_word  = words;
         push_job.stamp    = stamps;
         if (stopped_in) begin
            push_job.end_status = EndStopped;
         end else if (cont_block_in != 32'd0) begin
            push_job.end_status  = EndContinue;
            push_job.next_extent = cont_block_in;
            push_job.next_offset = cont_start_in;
            push_job.next_size   = cont_bytes_in;
         end else begin
            push_job.end_status = EndFinished;
         end

         push = px_hit || (tf_hit && flags[3:0] != 4'd0) || req_last;

         // The area end returns the parse to a fresh start.
         if (req_last) begin
            pos_in        = '0;
            len_in        = '0;
            stopped_in    = 1'b0;
            cont_block_in = '0;
            cont_start_in = '0;
            cont_bytes_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         len_ff        <= '0;
         stopped_ff    <= 1'b0;
         cont_block_ff <= '0;
         cont_start_ff <= '0;
         cont_bytes_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         stopped_ff    <= stopped_in;
         cont_block_ff <= cont_block_in;
         cont_start_ff <= cont_start_in;
         cont_bytes_ff <= cont_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
   end

endmodule

// File: hdl/rrap_queue.sv
// ----------------------------------------------------------------------------
// rrap_queue: job queue between front end and back end
// A small circular buffer of job records with a fill count.
// ----------------------------------------------------------------------------
module rrap_queue import rrap_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full || pop)
      else $error("job pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

// File: hdl/rrap_back.sv
// ----------------------------------------------------------------------------
// rrap_back: result sequencer
// Turns the job at the queue head into result items, one per cycle while the
// output register is free or being read, into a registered output stage.
// ----------------------------------------------------------------------------
module rrap_back import rrap_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic       started_ff, started_in;
   logic [3:0] mask_ff, mask_in;
   logic [1:0] slot_ff, slot_in;
   logic       body_done_ff, body_done_in;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       out_free;
   logic       load;
   logic [3:0] cur_mask;
   logic [1:0] cur_slot;
   logic       cur_done;
   logic [3:0] bit_sel;
   logic [1:0] flag_index;
   logic       last;
   result_type res;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = head_valid && out_free;

   assign cur_mask = started_ff ? mask_ff :
                     (head_job.is_tf ? head_job.tf_flags : 4'd0);
   assign cur_slot = started_ff ? slot_ff : 2'd0;
   assign cur_done = started_ff && body_done_ff;
   assign bit_sel  = cur_mask & (~cur_mask + 4'd1);

   always_comb begin
      priority if (cur_mask[0]) begin
         flag_index = 2'd0;
      end else if (cur_mask[1]) begin
         flag_index = 2'd1;
      end else if (cur_mask[2]) begin
         flag_index = 2'd2;
      end else begin
         flag_index = 2'd3;
      end
   end

   always_comb begin
      res          = '0;
      mask_in      = cur_mask;
      slot_in      = cur_slot;
      body_done_in = cur_done;
      if (!cur_done && head_job.is_px) begin
         res.kind       = KindPosix;
         res.file_mode  = head_job.px_word[0];
         res.link_count = head_job.px_word[1];
         res.owner_id   = head_job.px_word[2];
         res.group_id   = head_job.px_word[3];
         body_done_in   = 1'b1;
         last           = !head_job.has_end;
      end else if (!cur_done && cur_mask != 4'd0) begin
         res.kind         = KindStamp;
         res.stamp_target = stamp_target_of(flag_index);
         res.stamp_raw    = head_job.stamp[cur_slot];
         mask_in          = cur_mask & ~bit_sel;
         slot_in          = cur_slot + 2'd1;
         body_done_in     = (mask_in == 4'd0);
         last             = (mask_in == 4'd0) && !head_job.has_end;
      end else begin
         res.kind        = KindEnd;
         res.end_status  = head_job.end_status;
         res.next_extent = head_job.next_extent;
         res.next_offset = head_job.next_offset;
         res.next_size   = head_job.next_size;
         last            = 1'b1;
      end
      res.result_last = last;
      started_in      = started_ff;
      if (load) begin
         started_in = !last;
      end
   end

   assign pop       = load && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff       <= res;
         mask_ff      <= mask_in;
         slot_ff      <= slot_in;
         body_done_ff <= body_done_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |=> !started_ff)
      else $error("job still marked in progress after its pop");

   assert property (@(posedge clock) disable iff (reset) started_ff |-> head_valid)
      else $error("job in progress left the queue head");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KindEnd) |-> rsp_ff.result_last)
      else $error("end-of-area result not marked last");

endmodule

// File: hdl/rock_ridge_attribute_parser.sv
// ----------------------------------------------------------------------------
// rock_ridge_attribute_parser: Rock Ridge system-use entry parser
// Splits a system-use area into entries and reports posix attributes,
// timestamps and the end-of-area status with any continuation.
// ----------------------------------------------------------------------------
// The block takes one byte of a system-use area per transfer on the req_
// channel, with req_tlast on the final byte of the area, and accepts a byte
// every cycle as long as the job queue has room. Most bytes cause no result;
// the byte that completes a PX entry causes one result, the byte that
// completes a TF entry causes one result per stamp present, and the final
// byte of the area adds one end-of-area result, so a single byte causes up
// to five result transfers. Results leave the output register at one per
// cycle, so the sustained rate is one byte per cycle while the result stream
// keeps up; a byte that causes n results occupies the result sequencer until
// all n have left, and the QUEUE_DEPTH-entry job queue between intake and
// sequencer absorbs such bursts before req_tready drops. Fields that do
// not apply to a result's kind are zero, a cut-off entry at the area end is
// dropped, and each area starts from a fresh parse state.
// ----------------------------------------------------------------------------
module rock_ridge_attribute_parser import rrap_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // Byte stream of the system-use area.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] area_byte
   input  logic                   req_tlast,   // area_last
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] file_mode, [63:32] link_count, [95:64] owner_id,
   // [127:96] group_id, [129:128] stamp_target, [185:130] stamp_raw,
   // [187:186] end_status, [219:188] next_extent, [251:220] next_offset,
   // [283:252] next_size, [287:284] zero
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,   // [1:0] kind
   output logic                   rsp_tlast    // result_last
);

   logic       queue_full;
   logic       push;
   job_type    push_job;
   logic       pop;
   logic       head_valid;
   job_type    head_job;
   result_type rsp;

   // Intake: position tracking, byte capture and entry classification.
   rrap_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // Jobs wait here so that intake and result output stall independently.
   rrap_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Sequencer: expands each job into its result transfers.
   rrap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result record onto the stream ports, lowest field first.
   assign rsp_tdata = {4'b0000, rsp.next_size, rsp.next_offset, rsp.next_extent,
                       rsp.end_status, rsp.stamp_raw, rsp.stamp_target,
                       rsp.group_id, rsp.owner_id, rsp.link_count, rsp.file_mode};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.result_last;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Rock Ridge attribute parser
// Streams system-use areas into the parser one byte per transfer: a scripted
// set of entries first, then random areas that are mostly well-formed entry
// sequences with some broken or noisy ones. A behavioral parser in the bench
// predicts every result, and each received result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top import rrap_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KeepBytes    = 64;   // entry bytes the bench model retains
   localparam int ItemTarget   = 480;  // bytes to send over the whole run
   localparam int IdleLimit    = 500;  // cycles without any transfer
   localparam int DrainCycles  = 20;
   localparam logic [15:0] SigNm = 16'h4E4D;
   localparam logic [15:0] SigPn = 16'h504E;
   localparam logic [15:0] SigSl = 16'h534C;

   typedef enum logic [1:0] {FillZero, FillOnes, FillRandom} fill_kind_type;

   // One scripted entry. The bytes are signature, length, version 1, byte 4,
   // byte 5 and then the fill. sent = 0 sends the whole entry; otherwise that
   // many bytes are sent. last puts the area end on the final byte sent.
   typedef struct packed {
      logic [15:0]    sig;
      int             len;
      int             sent;
      logic [7:0]     b4;
      logic [7:0]     b5;
      fill_kind_type  fill;
      bit             last;
      bit             typed;    // expected end result written out below
      logic [1:0]     status;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   rsp_tlast;

   rock_ridge_attribute_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parse state mirrored by the bench.
   logic [7:0]  entry_bytes [0:KeepBytes-1];
   int unsigned entry_pos;
   int unsigned entry_len;
   bit          halted;
   logic [31:0] ce_extent, ce_offset, ce_size;

   result_type  results_due [$];
   logic [7:0]  area_bytes [$];

   int mismatch_count;
   int send_calm, take_calm;
   int bytes_sent, areas_sent, live_bytes;
   int kind_seen [0:3];
   int status_seen [0:3];

   task automatic note_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Gap before an item; now and then a stretch of back-to-back items.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm = $urandom_range(20, 60);
      return $urandom_range(0, 9);
   endfunction

   // Bytes beyond the entry length or the retained part read as zero.
   function automatic logic [7:0] entry_byte(input int unsigned i);
      if (i < entry_len && i < KeepBytes)
         return entry_bytes[i];
      return 8'h00;
   endfunction

   // Little-endian half of a both-endian word.
   function automatic logic [31:0] le_word(input int unsigned i);
      return {entry_byte(i + 3), entry_byte(i + 2), entry_byte(i + 1), entry_byte(i)};
   endfunction

   // Acts on a completed entry; returns how many results it queued.
   function automatic int close_entry();
      logic [15:0] sig;
      logic [7:0]  flags;
      logic [55:0] stamp;
      result_type  r;
      int          slot;
      int          n;
      sig   = {entry_byte(0), entry_byte(1)};
      flags = entry_byte(4);
      n     = 0;
      case (sig)
         SigRr: if ((flags & RrKnownMask) == 8'h00) halted = 1'b1;
         SigSp: if (entry_byte(4) != SpMagic0 || entry_byte(5) != SpMagic1) halted = 1'b1;
         SigRe: halted = 1'b1;
         SigCe: begin
            ce_extent = le_word(4);
            ce_offset = le_word(12);
            ce_size   = le_word(20);
         end
         SigPx: begin
            r            = '0;
            r.kind       = KindPosix;
            r.file_mode  = le_word(4);
            r.link_count = le_word(12);
            r.owner_id   = le_word(20);
            r.group_id   = le_word(28);
            results_due.push_back(r);
            n++;
         end
         SigTf: begin
            // Stamps are packed in flag order: create, modify, access,
            // attributes. Create and attributes both land on change time.
            slot = 0;
            for (int k = 0; k < 4; k++) begin
               if (flags[k]) begin
                  stamp = '0;
                  for (int b = 0; b < 7; b++)
                     stamp[8*b +: 8] = entry_byte(5 + 7*slot + b);
                  r              = '0;
                  r.kind         = KindStamp;
                  r.stamp_target = (k == 1) ? TargetModify :
                                   (k == 2) ? TargetAccess : TargetChange;
                  r.stamp_raw    = stamp;
                  results_due.push_back(r);
                  n++;
                  slot++;
               end
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   // Advances the mirrored parser by one accepted byte and queues its results.
   task automatic parse_area_byte(input logic [7:0] b, input bit at_end,
                                  output bit live, output int n);
      int unsigned pos;
      result_type  r;
      n    = 0;
      live = !halted;
      if (!halted) begin
         pos = entry_pos;
         if (pos < KeepBytes)
            entry_bytes[pos] = b;
         if (pos == LenPos) begin
            entry_len = b;
            if (b < MinEntryLen)
               halted = 1'b1;
         end
         if (!halted) begin
            if (pos >= VersionPos && pos + 1 == entry_len) begin
               n += close_entry();
               entry_pos = 0;
               entry_len = 0;
            end else begin
               entry_pos = (pos + 1) & 8'hFF;
            end
         end
      end
      if (at_end) begin
         r      = '0;
         r.kind = KindEnd;
         if (halted) begin
            r.end_status = EndStopped;
         end else if (ce_extent != 0) begin
            r.end_status  = EndContinue;
            r.next_extent = ce_extent;
            r.next_offset = ce_offset;
            r.next_size   = ce_size;
         end
         results_due.push_back(r);
         n++;
         // Every area begins from a fresh parse.
         entry_pos = 0;
         entry_len = 0;
         halted    = 1'b0;
         ce_extent = '0;
         ce_offset = '0;
         ce_size   = '0;
      end
      if (n > 0)
         results_due[results_due.size() - 1].result_last = 1'b1;
   endtask

   // Offers one byte after a random gap and predicts at its transfer edge.
   // Called right after the previous transfer edge, so tvalid is either kept
   // high or dropped here, never both in one step.
   task automatic send_area_byte(input logic [7:0] b, input bit at_end,
                                 output bit live, output int n);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= at_end;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      if (at_end)
         areas_sent++;
      parse_area_byte(b, at_end, live, n);
   endtask

   task automatic wait_for_drain();
      while (results_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] fill_byte(input fill_kind_type fill);
      case (fill)
         FillZero: return 8'h00;
         FillOnes: return 8'hFF;
         default:  return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Appends one random entry to area_bytes: mostly well-formed entries of
   // the handled kinds, some stopping ones and some of unknown signature.
   task automatic add_random_entry();
      logic [7:0]     e [$];
      logic [15:0]    sig;
      logic [7:0]     flags;
      fill_kind_type  fill;
      int             len;
      int             nbytes;
      int             pick;
      pick  = $urandom_range(0, 99);
      flags = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0:       fill = FillOnes;
         1:       fill = FillZero;
         default: fill = FillRandom;
      endcase
      if (pick < 30) begin
         sig = SigPx;
         len = ($urandom_range(0, 9) < 7) ? 36 : $urandom_range(4, 60);
         if ($urandom_range(0, 49) == 0)
            len = $urandom_range(200, 255);
      end else if (pick < 55) begin
         sig = SigTf;
         len = ($urandom_range(0, 9) < 8) ? 5 + 7 * $countones(flags[3:0])
                                          : $urandom_range(4, 40);
      end else if (pick < 65) begin
         sig = SigCe;
         len = ($urandom_range(0, 9) < 8) ? 28 : $urandom_range(4, 36);
      end else if (pick < 72) begin
         sig = SigRr;
         len = 5;
      end else if (pick < 78) begin
         sig = SigSp;
         len = 7;
      end else if (pick < 81) begin
         sig = SigRe;
         len = $urandom_range(4, 8);
      end else if (pick < 84) begin
         sig = SigPx;
         len = $urandom_range(0, 3);   // length below the header size
      end else begin
         case ($urandom_range(0, 3))
            0:       sig = SigNm;
            1:       sig = SigPn;
            2:       sig = SigSl;
            default: sig = 16'($urandom_range(0, 65535));
         endcase
         len = $urandom_range(4, 30);
      end

      nbytes = (len < 4) ? 3 : len;
      for (int i = 0; i < nbytes; i++)
         e.push_back(fill_byte(fill));
      e[0] = sig[15:8];
      e[1] = sig[7:0];
      e[2] = 8'(len);
      if (nbytes > 4) begin
         case (sig)
            SigTf, SigRr: e[4] = flags;
            SigCe: begin
               if ($urandom_range(0, 19) < 17) e[4] = 8'($urandom_range(1, 255));
               else e[4] = 8'h00;
            end
            default: ;
         endcase
      end
      if (sig == SigSp && $urandom_range(0, 4) != 0) begin
         e[4] = SpMagic0;
         e[5] = SpMagic1;
      end
      foreach (e[i])
         area_bytes.push_back(e[i]);
   endtask

   // Sends one whole area, the area end on its final byte.
   task automatic send_area();
      bit live;
      int n;
      int nb;
      nb = area_bytes.size();
      for (int i = 0; i < nb; i++) begin
         send_area_byte(area_bytes[i], i == nb - 1, live, n);
         if (live)
            live_bytes++;
      end
   endtask

   // The scripted part: every handled entry kind, short and long entries,
   // each way a parse can stop, cut-off entries and both continuation cases.
   script_row_type script_rows [0:24] = '{
      // A one-byte area holds only a cut-off entry.
      '{SigPx, 36, 1, 8'h00, 8'h00, FillRandom, 1'b1, 1'b1, EndFinished},
      '{SigPx, 36, 0, 8'hFF, 8'hFF, FillOnes,   1'b0, 1'b0, EndFinished},
      // Header-only PX entry: every word reads as zero.
      '{SigPx, 4,  0, 8'h00, 8'h00, FillZero,   1'b0, 1'b0, EndFinished},
      '{SigTf, 33, 0, 8'h0F, 8'h5A, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigTf, 12, 0, 8'h01, 8'hFF, FillOnes,   1'b0, 1'b0, EndFinished},
      // Stamps run past the entry length and read as zero.
      '{SigTf, 10, 0, 8'h0A, 8'h11, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigTf, 5,  0, 8'h00, 8'h00, FillZero,   1'b0, 1'b0, EndFinished},
      // Long form flag set; stamps stay seven bytes.
      '{SigTf, 12, 0, 8'h81, 8'h33, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigPx, 20, 0, 8'h01, 8'h02, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigNm, 10, 0, 8'h00, 8'h41, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigRr, 5,  0, 8'h80, 8'h00, FillZero,   1'b0, 1'b0, EndFinished},
      '{SigSp, 7,  0, SpMagic0, SpMagic1, FillRandom, 1'b0, 1'b0, EndFinished},
      '{SigCe, 28, 0, 8'h01, 8'h02, FillRandom, 1'b1, 1'b0, EndFinished},
      // Long entry: only the retained bytes count.
      '{SigPx, 70, 0, 8'hA4, 8'h81, FillRandom, 1'b0, 1'b0, EndFinished},
      // Four stamps plus the area end from a single byte.
      '{SigTf, 33, 0, 8'h0F, 8'hFF, FillOnes,   1'b1, 1'b0, EndFinished},
      // A stop discards the latched continuation.
      '{SigCe, 8,  0, 8'h07, 8'hFF, FillOnes,   1'b0, 1'b0, EndFinished},
      '{SigRe, 4,  0, 8'h00, 8'h00, FillZero,   1'b1, 1'b1, EndStopped},
      // RR with none of the known flags stops; the PX after it is ignored.
      '{SigRr, 5,  0, 8'h4A, 8'h00, FillZero,   1'b0, 1'b0, EndFinished},
      '{SigPx, 36, 8, 8'h12, 8'h34, FillRandom, 1'b1, 1'b1, EndStopped},
      '{SigSp, 7,  0, SpMagic0, 8'hEE, FillZero, 1'b1, 1'b1, EndStopped},
      // Length byte of zero, area end on that same byte.
      '{SigPx, 0,  3, 8'h00, 8'h00, FillZero,   1'b1, 1'b1, EndStopped},
      '{SigTf, 3,  8, 8'hFF, 8'hFF, FillOnes,   1'b1, 1'b1, EndStopped},
      '{SigPx, 36, 0, 8'h6D, 8'h41, FillRandom, 1'b1, 1'b0, EndFinished},
      '{SigNm, 20, 12, 8'h00, 8'h00, FillRandom, 1'b1, 1'b1, EndFinished},
      // CE with a zero block number asks for no continuation.
      '{SigCe, 8,  0, 8'h00, 8'h00, FillZero,   1'b1, 1'b1, EndFinished}
   };

   // Result side: a random stall before each result, then checking at the
   // transfer edge against the oldest expectation.
   initial begin : result_ready
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_gap(take_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   int idle_cycles;

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Watchdog: no transfer for %0d cycles", IdleLimit);
            $display("Test completed with failures");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got              = '0;
            got.kind         = rsp_tuser;
            got.file_mode    = rsp_tdata[31:0];
            got.link_count   = rsp_tdata[63:32];
            got.owner_id     = rsp_tdata[95:64];
            got.group_id     = rsp_tdata[127:96];
            got.stamp_target = rsp_tdata[129:128];
            got.stamp_raw    = rsp_tdata[185:130];
            got.end_status   = rsp_tdata[187:186];
            got.next_extent  = rsp_tdata[219:188];
            got.next_offset  = rsp_tdata[251:220];
            got.next_size    = rsp_tdata[283:252];
            got.result_last  = rsp_tlast;
            kind_seen[got.kind]++;
            if (got.kind == KindEnd)
               status_seen[got.end_status]++;
            if (results_due.size() == 0) begin
               note_mismatch($sformatf("result of kind %0d with nothing due", got.kind));
            end else begin
               want = results_due.pop_front();
               check_field("kind", got.kind, want.kind);
               check_field("file_mode", got.file_mode, want.file_mode);
               check_field("link_count", got.link_count, want.link_count);
               check_field("owner_id", got.owner_id, want.owner_id);
               check_field("group_id", got.group_id, want.group_id);
               check_field("stamp_target", got.stamp_target, want.stamp_target);
               check_field("stamp_raw", got.stamp_raw, want.stamp_raw);
               check_field("end_status", got.end_status, want.end_status);
               check_field("next_extent", got.next_extent, want.next_extent);
               check_field("next_offset", got.next_offset, want.next_offset);
               check_field("next_size", got.next_size, want.next_size);
               check_field("result_last", got.result_last, want.result_last);
               check_field("padding", rsp_tdata[RspDataBits-1:284], '0);
            end
         end
      end
   end

   initial begin : stimulus
      script_row_type row;
      result_type     typed_end;
      logic [7:0]     b;
      bit             live;
      int             n;
      int             nb;
      entry_pos = 0;
      entry_len = 0;
      halted    = 1'b0;
      ce_extent = '0;
      ce_offset = '0;
      ce_size   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script_rows[r]) begin
         row = script_rows[r];
         nb  = (row.sent != 0) ? row.sent : row.len;
         for (int i = 0; i < nb; i++) begin
            case (i)
               0:       b = row.sig[15:8];
               1:       b = row.sig[7:0];
               2:       b = 8'(row.len);
               3:       b = 8'h01;
               4:       b = row.b4;
               5:       b = row.b5;
               default: b = fill_byte(row.fill);
            endcase
            send_area_byte(b, row.last && i == nb - 1, live, n);
         end
         if (row.typed) begin
            // Replace what the byte predicted with the end result read off
            // the script: only a status, everything else zero.
            repeat (n) void'(results_due.pop_back());
            typed_end             = '0;
            typed_end.kind        = KindEnd;
            typed_end.end_status  = row.status;
            typed_end.result_last = 1'b1;
            results_due.push_back(typed_end);
         end
         // Hold the byte stream once until the result stream has caught up.
         if (r == 12) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
      end

      while (bytes_sent < ItemTarget) begin
         area_bytes.delete();
         if ($urandom_range(0, 19) == 0) begin
            // Noise area: raw bytes with no entry structure.
            repeat ($urandom_range(1, 12))
               area_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4))
               add_random_entry();
            case ($urandom_range(0, 19))
               0, 1:    while (area_bytes.size() > 1 && $urandom_range(0, 3) != 0)
                           void'(area_bytes.pop_back());
               2:       area_bytes.push_back(8'($urandom_range(0, 255)));
               default: ;
            endcase
         end
         send_area();
         if ($urandom_range(0, 11) == 0) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
      end

      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);

      if (results_due.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", results_due.size()));
      $display("Sent %0d bytes in %0d areas, %0d parsed bytes in the random part.",
                bytes_sent, areas_sent, live_bytes);
      $display("Received %0d posix, %0d stamp, %0d end (%0d continue, %0d stopped).",
               kind_seen[KindPosix], kind_seen[KindStamp], kind_seen[KindEnd],
               status_seen[EndContinue], status_seen[EndStopped]);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
